>>> sv/bpc_pkg.sv
// Shared constants and types of the button press classifier with beeper.
package bpc_pkg;

    // Button lanes and the width of the flag fields on the result port.
    localparam int NUM_BUTTONS = 5;
    localparam int FLAG_W      = 5;
    localparam int CNT_W       = 16;
    localparam int BEEP_W      = 8;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Beep that a short press asks for.
    localparam logic [BEEP_W-1:0] PRESS_BEEP_LEN     = 8'd2;
    localparam logic [BEEP_W-1:0] PRESS_BEEP_GAP     = 8'd2;
    localparam logic [BEEP_W-1:0] PRESS_BEEP_REPEATS = 8'd1;

    // Request opcodes.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    // Register indexes (byte address bits [3:2]).
    localparam logic [1:0] REG_SHORT_MIN     = 2'd0;
    localparam logic [1:0] REG_SHORT_MAX     = 2'd1;
    localparam logic [1:0] REG_LONG_MIN      = 2'd2;
    localparam logic [1:0] REG_BEEP_ON_PRESS = 2'd3;

    // Register reset values.
    localparam logic [CNT_W-1:0] SHORT_MIN_RST = 16'd5;
    localparam logic [CNT_W-1:0] SHORT_MAX_RST = 16'd50;
    localparam logic [CNT_W-1:0] LONG_MIN_RST  = 16'd100;

    typedef struct packed {
        logic held;
        logic short_press;
        logic long_press;
    } flags_t;

    typedef struct packed {
        logic [CNT_W-1:0] short_min;
        logic [CNT_W-1:0] short_max;
        logic [CNT_W-1:0] long_min;
    } thresh_t;

    typedef struct packed {
        logic [BEEP_W-1:0] on_len;
        logic [BEEP_W-1:0] gap_len;
        logic [BEEP_W-1:0] repeats;
    } beep_cmd_t;

    typedef struct packed {
        logic [FLAG_W-1:0] held;
        logic [FLAG_W-1:0] short_press;
        logic [FLAG_W-1:0] long_press;
        logic              speaker;
    } result_t;

endpackage

>>> sv/bpc_lane.sv
// One button lane: hold counter and press classification flags.
module bpc_lane (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tick,
    input  logic             level,
    input  bpc_pkg::thresh_t thresh,
    output bpc_pkg::flags_t  flags,
    output logic             beep_req
);

    logic [bpc_pkg::CNT_W-1:0] cnt_reg;
    logic [bpc_pkg::CNT_W-1:0] cnt_next;
    bpc_pkg::flags_t           flags_reg;
    bpc_pkg::flags_t           flags_next;

    // Count while held, clear on release or wrap, then classify the new count.
    always_comb
    begin
        bpc_pkg::flags_t base;
        base       = flags_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        beep_req   = 1'b0;
        if (tick)
        begin
            if (level && (cnt_reg != bpc_pkg::COUNT_MAX))
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                cnt_next = '0;
                base     = '0;
            end
            flags_next = base;
            if (cnt_next > thresh.long_min)
            begin
                flags_next = '{held: 1'b1, short_press: 1'b0, long_press: 1'b1};
            end
            else if (cnt_next > thresh.short_max)
            begin
                flags_next = '{held: 1'b1, short_press: 1'b0, long_press: 1'b0};
            end
            else if (cnt_next >= thresh.short_min)
            begin
                flags_next = '{held: 1'b1, short_press: 1'b1, long_press: 1'b0};
                beep_req   = 1'b1;
            end
        end
    end

    // Lane state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flags_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flags_reg <= flags_next;
        end
    end

    // Flags as they stand after this request.
    assign flags = flags_next;

endmodule

>>> sv/bpc_beeper.sv
// Beeper: on-length, gap and repeat counters that drive the speaker bit.
module bpc_beeper (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               cmd_load,
    input  logic               press_req,
    input  bpc_pkg::beep_cmd_t cmd,
    output logic               speaker
);

    logic [bpc_pkg::BEEP_W-1:0] on_len_reg,  on_len_next;
    logic [bpc_pkg::BEEP_W-1:0] gap_len_reg, gap_len_next;
    logic [bpc_pkg::BEEP_W-1:0] beeps_reg,   beeps_next;
    logic [bpc_pkg::BEEP_W-1:0] gap_cnt_reg, gap_cnt_next;
    logic [bpc_pkg::BEEP_W-1:0] on_cnt_reg,  on_cnt_next;
    logic                       spk_reg,     spk_next;

    // Load from a command or a press, then advance the counters on a tick.
    always_comb
    begin
        on_len_next  = on_len_reg;
        gap_len_next = gap_len_reg;
        beeps_next   = beeps_reg;
        gap_cnt_next = gap_cnt_reg;
        on_cnt_next  = on_cnt_reg;
        spk_next     = spk_reg;
        if (cmd_load)
        begin
            on_len_next  = cmd.on_len;
            gap_len_next = cmd.gap_len;
            beeps_next   = cmd.repeats;
        end
        else if (tick && press_req)
        begin
            on_len_next  = bpc_pkg::PRESS_BEEP_LEN;
            gap_len_next = bpc_pkg::PRESS_BEEP_GAP;
            beeps_next   = bpc_pkg::PRESS_BEEP_REPEATS;
        end
        if (tick && (beeps_next != '0))
        begin
            gap_cnt_next = gap_cnt_reg + 1'b1;
            if (gap_cnt_reg == gap_len_next)
            begin
                gap_cnt_next = '0;
                spk_next     = 1'b1;
                on_cnt_next  = on_cnt_reg + 1'b1;
                if (on_cnt_reg == on_len_next)
                begin
                    on_cnt_next = '0;
                    spk_next    = 1'b0;
                    beeps_next  = beeps_next - 1'b1;
                end
            end
        end
    end

    // Beeper state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_len_reg  <= '0;
            gap_len_reg <= '0;
            beeps_reg   <= '0;
            gap_cnt_reg <= '0;
            on_cnt_reg  <= '0;
            spk_reg     <= 1'b0;
        end
        else
        begin
            on_len_reg  <= on_len_next;
            gap_len_reg <= gap_len_next;
            beeps_reg   <= beeps_next;
            gap_cnt_reg <= gap_cnt_next;
            on_cnt_reg  <= on_cnt_next;
            spk_reg     <= spk_next;
        end
    end

    // Speaker level after this request.
    assign speaker = spk_next;

endmodule

>>> sv/button_press_classifier_with_beeper.sv
// Top level: register port, button lanes, result merge, beeper and output skid stage.
//
// Each request is either a tick carrying the button levels or a command that
// loads the beeper, and each returns one result with the held, short-press and
// long-press flags and the speaker level after that request. The block takes
// one request per clock cycle while in_ready is high, and the result is registered;
// every button has its own lane with a hold counter and three threshold compares,
// a merge stage gathers the lane flags and any short-press beep request, and the
// beeper advances in the same cycle. An output register backed by a one-entry skid
// register lets a request enter while a result still waits; in_ready drops only while
// both hold results. Thresholds and the press-beep enable are to be written over the
// register port only while no request is in flight; the block does not enforce this.
module button_press_classifier_with_beeper (
    input  logic                           clk,
    input  logic                           rst_n,
    // Register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]     paddr,
    input  logic [bpc_pkg::DATA_W-1:0]     pwdata,
    output logic [bpc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    // Request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic [bpc_pkg::FLAG_W-1:0]     button_levels,
    input  logic [bpc_pkg::BEEP_W-1:0]     beep_length,
    input  logic [bpc_pkg::BEEP_W-1:0]     beep_gap,
    input  logic [bpc_pkg::BEEP_W-1:0]     beep_repeats,
    // Result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bpc_pkg::FLAG_W-1:0]     held_flags,
    output logic [bpc_pkg::FLAG_W-1:0]     short_flags,
    output logic [bpc_pkg::FLAG_W-1:0]     long_flags,
    output logic                           speaker_on
);

    bpc_pkg::thresh_t              thresh_reg;
    logic                          beep_on_press_reg;
    logic                          cfg_wr;
    logic                          accept;
    logic                          tick;
    logic                          cmd_load;
    logic                          out_take;
    logic                          press_req;
    logic                          speaker;
    logic [bpc_pkg::NUM_BUTTONS-1:0] lane_req;
    bpc_pkg::flags_t               lane_flags [bpc_pkg::NUM_BUTTONS];
    bpc_pkg::beep_cmd_t            cmd;
    bpc_pkg::result_t              result;
    bpc_pkg::result_t              out_reg;
    bpc_pkg::result_t              skid_reg;
    logic                          out_valid_reg;
    logic                          skid_valid_reg;

    // Register port: writes complete in the access cycle, reads are direct.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.short_min <= bpc_pkg::SHORT_MIN_RST;
            thresh_reg.short_max <= bpc_pkg::SHORT_MAX_RST;
            thresh_reg.long_min  <= bpc_pkg::LONG_MIN_RST;
            beep_on_press_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                bpc_pkg::REG_SHORT_MIN:     thresh_reg.short_min <= pwdata[bpc_pkg::CNT_W-1:0];
                bpc_pkg::REG_SHORT_MAX:     thresh_reg.short_max <= pwdata[bpc_pkg::CNT_W-1:0];
                bpc_pkg::REG_LONG_MIN:      thresh_reg.long_min  <= pwdata[bpc_pkg::CNT_W-1:0];
                bpc_pkg::REG_BEEP_ON_PRESS: beep_on_press_reg    <= pwdata[0];
                default:                    beep_on_press_reg    <= beep_on_press_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bpc_pkg::REG_SHORT_MIN:
                prdata = {{(bpc_pkg::DATA_W-bpc_pkg::CNT_W){1'b0}}, thresh_reg.short_min};
            bpc_pkg::REG_SHORT_MAX:
                prdata = {{(bpc_pkg::DATA_W-bpc_pkg::CNT_W){1'b0}}, thresh_reg.short_max};
            bpc_pkg::REG_LONG_MIN:
                prdata = {{(bpc_pkg::DATA_W-bpc_pkg::CNT_W){1'b0}}, thresh_reg.long_min};
            bpc_pkg::REG_BEEP_ON_PRESS:
                prdata = {{(bpc_pkg::DATA_W-1){1'b0}}, beep_on_press_reg};
            default:
                prdata = '0;
        endcase
    end

    // Request handshake and decode.
    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign tick     = accept && (opcode == bpc_pkg::OP_TICK);
    assign cmd_load = accept && (opcode == bpc_pkg::OP_CMD);
    assign cmd      = '{on_len: beep_length, gap_len: beep_gap, repeats: beep_repeats};

    // Button lanes; buttons past the level field always read as released.
    for (genvar i = 0; i < bpc_pkg::NUM_BUTTONS; i++)
    begin : g_lane
        logic level;
        if (i < bpc_pkg::FLAG_W)
        begin : g_pin
            assign level = button_levels[i];
        end
        else
        begin : g_none
            assign level = 1'b0;
        end
        bpc_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .tick     (tick),
            .level    (level),
            .thresh   (thresh_reg),
            .flags    (lane_flags[i]),
            .beep_req (lane_req[i])
        );
    end

    // Merge: any lane in the short range asks for the press beep.
    assign press_req = beep_on_press_reg && (|lane_req);

    for (genvar j = 0; j < bpc_pkg::FLAG_W; j++)
    begin : g_merge
        if (j < bpc_pkg::NUM_BUTTONS)
        begin : g_used
            assign result.held[j]        = lane_flags[j].held;
            assign result.short_press[j] = lane_flags[j].short_press;
            assign result.long_press[j]  = lane_flags[j].long_press;
        end
        else
        begin : g_unused
            assign result.held[j]        = 1'b0;
            assign result.short_press[j] = 1'b0;
            assign result.long_press[j]  = 1'b0;
        end
    end

    bpc_beeper u_beeper (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .cmd_load  (cmd_load),
        .press_req (press_req),
        .cmd       (cmd),
        .speaker   (speaker)
    );

    assign result.speaker = speaker;

    // Output register and skid register: valid bits.
    assign out_take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    // Output register and skid register: payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (out_take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign held_flags  = out_reg.held;
    assign short_flags = out_reg.short_press;
    assign long_flags  = out_reg.long_press;
    assign speaker_on  = out_reg.speaker;

    // The skid register only fills behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // A request taken while the output is stalled lands in the skid register.
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("request taken during a stall was not parked in the skid register");

    // Short and long flags only appear on held buttons and never together.
    a_flag_nesting: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((((out_reg.short_press | out_reg.long_press) & ~out_reg.held) == '0)
                           && ((out_reg.short_press & out_reg.long_press) == '0)))
        else $error("press flags are inconsistent");

endmodule

>>> dv/press_checker.sv
// Checker for the button press classifier: tracks register writes, predicts results, compares.
module press_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]     paddr,
    input  logic [bpc_pkg::DATA_W-1:0]     pwdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           opcode,
    input  logic [bpc_pkg::FLAG_W-1:0]     button_levels,
    input  logic [bpc_pkg::BEEP_W-1:0]     beep_length,
    input  logic [bpc_pkg::BEEP_W-1:0]     beep_gap,
    input  logic [bpc_pkg::BEEP_W-1:0]     beep_repeats,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [bpc_pkg::FLAG_W-1:0]     held_flags,
    input  logic [bpc_pkg::FLAG_W-1:0]     short_flags,
    input  logic [bpc_pkg::FLAG_W-1:0]     long_flags,
    input  logic                           speaker_on,
    output int                             outstanding,
    output int                             mismatches
);
    import bpc_pkg::*;

    // Shadow copy of the thresholds and the press-beep enable.
    logic [CNT_W-1:0]  short_min;
    logic [CNT_W-1:0]  short_max;
    logic [CNT_W-1:0]  long_min;
    logic              press_beep;

    // Predicted button and beeper state.
    logic [CNT_W-1:0]  hold_cnt [NUM_BUTTONS];
    logic [FLAG_W-1:0] held_st;
    logic [FLAG_W-1:0] short_st;
    logic [FLAG_W-1:0] long_st;
    logic [BEEP_W-1:0] on_len;
    logic [BEEP_W-1:0] gap_len;
    logic [BEEP_W-1:0] beeps_left;
    logic [BEEP_W-1:0] gap_cnt;
    logic [BEEP_W-1:0] on_cnt;
    logic              speaker;

    // Flags and speaker level still owed by the block, oldest first.
    result_t           owed_flags [$];
    int                err_cnt = 0;

    // Applies one request to the predicted state and returns the flags it leaves.
    function automatic result_t step_buttons_and_beeper(
        input logic              op,
        input logic [FLAG_W-1:0] levels,
        input logic [BEEP_W-1:0] len,
        input logic [BEEP_W-1:0] gap,
        input logic [BEEP_W-1:0] reps
    );
        result_t           r;
        logic [CNT_W-1:0]  c;
        logic [BEEP_W-1:0] g;
        logic [BEEP_W-1:0] o;
        if (op == OP_TICK)
        begin
            for (int i = NUM_BUTTONS - 1; i >= 0; i--)
            begin
                // A release, or a hold at the top count, restarts the lane.
                c = hold_cnt[i];
                if (levels[i] && c != COUNT_MAX)
                    c = c + 1'b1;
                else
                begin
                    c = '0;
                    held_st[i]  = 1'b0;
                    short_st[i] = 1'b0;
                    long_st[i]  = 1'b0;
                end
                hold_cnt[i] = c;

                // Threshold compares, long range first.
                if (c > long_min)
                begin
                    held_st[i]  = 1'b1;
                    short_st[i] = 1'b0;
                    long_st[i]  = 1'b1;
                end
                else if (c > short_max)
                begin
                    held_st[i]  = 1'b1;
                    short_st[i] = 1'b0;
                    long_st[i]  = 1'b0;
                end
                else if (c >= short_min)
                begin
                    if (press_beep)
                    begin
                        on_len     = PRESS_BEEP_LEN;
                        gap_len    = PRESS_BEEP_GAP;
                        beeps_left = PRESS_BEEP_REPEATS;
                    end
                    held_st[i]  = 1'b1;
                    short_st[i] = 1'b1;
                    long_st[i]  = 1'b0;
                end
            end

            // The beeper advances once per tick while beeps remain.
            if (beeps_left != 0)
            begin
                g = gap_cnt;
                gap_cnt = g + 1'b1;
                if (g == gap_len)
                begin
                    gap_cnt = '0;
                    speaker = 1'b1;
                    o = on_cnt;
                    on_cnt = o + 1'b1;
                    if (o == on_len)
                    begin
                        on_cnt = '0;
                        speaker = 1'b0;
                        beeps_left = beeps_left - 1'b1;
                    end
                end
            end
        end
        else
        begin
            on_len     = len;
            gap_len    = gap;
            beeps_left = reps;
        end
        r.held        = held_st;
        r.short_press = short_st;
        r.long_press  = long_st;
        r.speaker     = speaker;
        return r;
    endfunction

    // Counts a wrong field and reports the first few.
    function automatic void note_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch on %s: expected 'h%0h, got 'h%0h", what, want, got);
    endfunction

    // Watch the register port and both channels on every clock edge.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            short_min  = SHORT_MIN_RST;
            short_max  = SHORT_MAX_RST;
            long_min   = LONG_MIN_RST;
            press_beep = 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++)
                hold_cnt[i] = '0;
            held_st    = '0;
            short_st   = '0;
            long_st    = '0;
            on_len     = '0;
            gap_len    = '0;
            beeps_left = '0;
            gap_cnt    = '0;
            on_cnt     = '0;
            speaker    = 1'b0;
            owed_flags.delete();
            outstanding <= 0;
            mismatches  <= err_cnt;
        end
        else
        begin
            // Register writes land in the shadow copy.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SHORT_MIN:     short_min  = pwdata[CNT_W-1:0];
                    REG_SHORT_MAX:     short_max  = pwdata[CNT_W-1:0];
                    REG_LONG_MIN:      long_min   = pwdata[CNT_W-1:0];
                    REG_BEEP_ON_PRESS: press_beep = pwdata[0];
                    default: ;
                endcase
            end

            // A result can only belong to a request taken on an earlier edge.
            if (out_valid && out_ready)
            begin
                if (owed_flags.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("result with no request outstanding: held 'h%0h",
                                 held_flags);
                end
                else
                begin
                    want = owed_flags.pop_front();
                    if (held_flags !== want.held)
                        note_mismatch("held_flags", want.held, held_flags);
                    if (short_flags !== want.short_press)
                        note_mismatch("short_flags", want.short_press, short_flags);
                    if (long_flags !== want.long_press)
                        note_mismatch("long_flags", want.long_press, long_flags);
                    if (speaker_on !== want.speaker)
                        note_mismatch("speaker_on", want.speaker, speaker_on);
                end
            end

            if (in_valid && in_ready)
                owed_flags.push_back(step_buttons_and_beeper(opcode, button_levels,
                                                             beep_length, beep_gap,
                                                             beep_repeats));

            outstanding <= owed_flags.size();
            mismatches  <= err_cnt;
        end
    end

endmodule

>>> dv/testbench.sv
// Top of the button press classifier testbench: clock, reset, stimulus and verdict.
module testbench;
    import bpc_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              opcode = OP_TICK;
    logic [FLAG_W-1:0] button_levels = '0;
    logic [BEEP_W-1:0] beep_length = '0;
    logic [BEEP_W-1:0] beep_gap = '0;
    logic [BEEP_W-1:0] beep_repeats = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [FLAG_W-1:0] held_flags;
    logic [FLAG_W-1:0] short_flags;
    logic [FLAG_W-1:0] long_flags;
    logic              speaker_on;

    int                outstanding;
    int                mismatches;

    button_press_classifier_with_beeper DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .button_levels (button_levels),
        .beep_length   (beep_length),
        .beep_gap      (beep_gap),
        .beep_repeats  (beep_repeats),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .held_flags    (held_flags),
        .short_flags   (short_flags),
        .long_flags    (long_flags),
        .speaker_on    (speaker_on)
    );

    press_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .button_levels (button_levels),
        .beep_length   (beep_length),
        .beep_gap      (beep_gap),
        .beep_repeats  (beep_repeats),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .held_flags    (held_flags),
        .short_flags   (short_flags),
        .long_flags    (long_flags),
        .speaker_on    (speaker_on),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    always #2 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pause_len();
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(8, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // Offers one request and holds it until taken, then maybe idles.
    task automatic send_request(input logic op, input logic [FLAG_W-1:0] levels,
                                input logic [BEEP_W-1:0] len, input logic [BEEP_W-1:0] gap,
                                input logic [BEEP_W-1:0] reps);
        int pause;
        opcode        <= op;
        button_levels <= levels;
        beep_length   <= len;
        beep_gap      <= gap;
        beep_repeats  <= reps;
        in_valid      <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pause = pause_len();
        if (pause != 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // A tick carries random values in the fields it ignores.
    task automatic send_tick(input logic [FLAG_W-1:0] levels);
        send_request(OP_TICK, levels, $urandom, $urandom, $urandom);
    endtask

    task automatic send_command(input logic [BEEP_W-1:0] len, input logic [BEEP_W-1:0] gap,
                                input logic [BEEP_W-1:0] reps);
        send_request(OP_CMD, $urandom, len, gap, reps);
    endtask

    // Stops offering requests and waits until every result is back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // New thresholds and beep enable, written only once the block is idle.
    task automatic set_thresholds(input logic [CNT_W-1:0] smin, input logic [CNT_W-1:0] smax,
                                  input logic [CNT_W-1:0] lmin, input logic beep);
        wait_idle();
        write_reg(REG_SHORT_MIN, smin);
        write_reg(REG_SHORT_MAX, smax);
        write_reg(REG_LONG_MIN, lmin);
        write_reg(REG_BEEP_ON_PRESS, {15'd0, beep});
    endtask

    // Random traffic: buttons held for runs whose length depends on flip_odds,
    // some beeper commands, and now and then a fully random level pattern.
    task automatic run_mix(input int count, input int flip_odds);
        logic [FLAG_W-1:0] levels;
        levels = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_command($urandom, $urandom, $urandom);
                else
                    send_command($urandom_range(0, 4), $urandom_range(0, 4),
                                 $urandom_range(0, 3));
            end
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    levels = $urandom;
                else
                    for (int b = 0; b < FLAG_W; b++)
                        if ($urandom_range(0, flip_odds) == 0)
                            levels[b] = ~levels[b];
                send_tick(levels);
            end
        end
    endtask

    // Result side: ready runs broken by stalls, sometimes long stretches without.
    initial
    begin
        int run;
        int stall;
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            stall = pause_len();
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds, then beeper commands at the field extremes.
        send_tick(5'b00000);
        send_tick(5'b11111);
        send_tick(5'b11111);
        send_command(8'hFF, 8'hFF, 8'hFF);
        send_command(8'h00, 8'h00, 8'h00);

        // Tight thresholds: short press with beep, plain press, long press, release.
        set_thresholds(16'd1, 16'd2, 16'd3, 1'b1);
        repeat (4) send_tick(5'b11111);
        send_tick(5'b01010);
        send_tick(5'b10101);
        send_command(8'd0, 8'd0, 8'd2);
        repeat (3) send_tick(5'b00000);
        send_command(8'd3, 8'd1, 8'd2);
        repeat (3) send_tick(5'b00000);
        // Zero repeat count halts the beeper mid-beep.
        send_command(8'd0, 8'd0, 8'd0);
        repeat (2) send_tick(5'b00000);

        // All thresholds zero: released buttons report a short press.
        set_thresholds(16'd0, 16'd0, 16'd0, 1'b0);
        repeat (2) send_tick(5'b00000);
        send_tick(5'b11111);

        // Random phases over several threshold settings.
        set_thresholds(16'd1, 16'd4, 16'd8, 1'b1);
        run_mix(160, 6);
        set_thresholds(16'd3, 16'd12, 16'd20, 1'b0);
        run_mix(160, 10);
        set_thresholds($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                       $urandom_range(0, 1));
        run_mix(160, 8);
        set_thresholds(SHORT_MIN_RST, SHORT_MAX_RST, LONG_MIN_RST, 1'b1);
        run_mix(160, 60);
        set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        run_mix(160, 8);
        set_thresholds(16'd1, 16'd1, 16'd1, 1'b0);
        run_mix(160, 4);
        set_thresholds(16'd0, 16'd0, 16'd0, 1'b1);
        run_mix(160, 6);

        wait_idle();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
sv/bpc_pkg.sv
sv/bpc_lane.sv
sv/bpc_beeper.sv
sv/button_press_classifier_with_beeper.sv
dv/press_checker.sv
dv/testbench.sv
